/* hdl/obsc_pkg.sv */
package obsc_pkg;

  localparam int CMD_W   = 3;
  localparam int AGENT_IN_W = 6;
  localparam int STOCK_IN_W = 2;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 24;
  localparam int CASH_W  = 48;
  localparam int HOLD_W  = 32;
  localparam int TOTAL_W = 32;
  localparam int TRADES_W = 9;
  localparam int COST_W  = 56;
  localparam int FEE_W   = 32;

  localparam logic [FEE_W-1:0] FEE_KEEP_RESET = 32'd4294537799;

  localparam logic [CMD_W-1:0] CMD_LOAD_CASH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_HOLD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_BID   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_ASK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MATCH     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EMPTY     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd6;

  // Controller states; the datapath runs the step named by the state.
  localparam int OP_W = 6;
  localparam logic [OP_W-1:0] OP_IDLE      = 6'd0;
  localparam logic [OP_W-1:0] OP_CLR       = 6'd1;
  localparam logic [OP_W-1:0] OP_DISP      = 6'd2;
  localparam logic [OP_W-1:0] OP_LOAD_CASH = 6'd3;
  localparam logic [OP_W-1:0] OP_LOAD_HOLD = 6'd4;
  localparam logic [OP_W-1:0] OP_EMPTY     = 6'd5;
  localparam logic [OP_W-1:0] OP_NOP       = 6'd6;
  localparam logic [OP_W-1:0] OP_WAL_RD    = 6'd7;
  localparam logic [OP_W-1:0] OP_WAL_OUT   = 6'd8;
  localparam logic [OP_W-1:0] OP_INS_INIT  = 6'd9;
  localparam logic [OP_W-1:0] OP_INS_RD    = 6'd10;
  localparam logic [OP_W-1:0] OP_INS_CMP   = 6'd11;
  localparam logic [OP_W-1:0] OP_INS_PUT   = 6'd12;
  localparam logic [OP_W-1:0] OP_FULL      = 6'd13;
  localparam logic [OP_W-1:0] OP_M_INIT    = 6'd14;
  localparam logic [OP_W-1:0] OP_M_TEST    = 6'd15;
  localparam logic [OP_W-1:0] OP_M_RD      = 6'd16;
  localparam logic [OP_W-1:0] OP_M_PAIR    = 6'd17;
  localparam logic [OP_W-1:0] OP_M_COST    = 6'd18;
  localparam logic [OP_W-1:0] OP_M_CHK     = 6'd19;
  localparam logic [OP_W-1:0] OP_M_KEEP    = 6'd20;
  localparam logic [OP_W-1:0] OP_M_PAY     = 6'd21;
  localparam logic [OP_W-1:0] OP_M_SRD     = 6'd22;
  localparam logic [OP_W-1:0] OP_M_SPUT    = 6'd23;
  localparam logic [OP_W-1:0] OP_RD_CASH_B = 6'd24;
  localparam logic [OP_W-1:0] OP_FMAG_B    = 6'd25;
  localparam logic [OP_W-1:0] OP_FHI_B     = 6'd26;
  localparam logic [OP_W-1:0] OP_FLO_B     = 6'd27;
  localparam logic [OP_W-1:0] OP_FPUT_B    = 6'd28;
  localparam logic [OP_W-1:0] OP_RD_CASH_S = 6'd29;
  localparam logic [OP_W-1:0] OP_FMAG_S    = 6'd30;
  localparam logic [OP_W-1:0] OP_FHI_S     = 6'd31;
  localparam logic [OP_W-1:0] OP_FLO_S     = 6'd32;
  localparam logic [OP_W-1:0] OP_FPUT_S    = 6'd33;
  localparam logic [OP_W-1:0] OP_RD_HOLD_B = 6'd34;
  localparam logic [OP_W-1:0] OP_HPUT_B    = 6'd35;
  localparam logic [OP_W-1:0] OP_RD_HOLD_S = 6'd36;
  localparam logic [OP_W-1:0] OP_HPUT_S    = 6'd37;
  localparam logic [OP_W-1:0] OP_M_ADV     = 6'd38;
  localparam logic [OP_W-1:0] OP_BC_TEST   = 6'd39;
  localparam logic [OP_W-1:0] OP_BC_RD     = 6'd40;
  localparam logic [OP_W-1:0] OP_BC_WR     = 6'd41;
  localparam logic [OP_W-1:0] OP_AC_TEST   = 6'd42;
  localparam logic [OP_W-1:0] OP_AC_RD     = 6'd43;
  localparam logic [OP_W-1:0] OP_AC_WR     = 6'd44;
  localparam logic [OP_W-1:0] OP_M_END     = 6'd45;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             side_full;
    logic             side_empty;
    logic             ins_shift;
    logic             p_is_one;
    logic             loop_more;
    logic             trade_ok;
    logic             bid_more;
    logic             ask_more;
    logic             clr_last;
  } dp_status_t;

endpackage

/* hdl/obsc_ram.sv */
module obsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/obsc_ctrl.sv */
module obsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  obsc_pkg::dp_status_t st,
  output obsc_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  logic [obsc_pkg::OP_W-1:0] state;
  logic [obsc_pkg::OP_W-1:0] state_next;

  assign busy     = (state != obsc_pkg::OP_IDLE);
  assign cmd.op   = state;
  assign cmd.load = (state == obsc_pkg::OP_IDLE) && start;

  always_comb begin
    state_next = state;
    case (state)
      obsc_pkg::OP_CLR:      if (st.clr_last) state_next = obsc_pkg::OP_IDLE;
      obsc_pkg::OP_IDLE:     if (start) state_next = obsc_pkg::OP_DISP;
      obsc_pkg::OP_DISP: begin
        case (st.cmd)
          obsc_pkg::CMD_LOAD_CASH: state_next = obsc_pkg::OP_LOAD_CASH;
          obsc_pkg::CMD_LOAD_HOLD: state_next = obsc_pkg::OP_LOAD_HOLD;
          obsc_pkg::CMD_ADD_BID:   state_next = obsc_pkg::OP_INS_INIT;
          obsc_pkg::CMD_ADD_ASK:   state_next = obsc_pkg::OP_INS_INIT;
          obsc_pkg::CMD_MATCH:     state_next = obsc_pkg::OP_M_INIT;
          obsc_pkg::CMD_EMPTY:     state_next = obsc_pkg::OP_EMPTY;
          obsc_pkg::CMD_READ:      state_next = obsc_pkg::OP_WAL_RD;
          default:                 state_next = obsc_pkg::OP_NOP;
        endcase
      end
      obsc_pkg::OP_WAL_RD:   state_next = obsc_pkg::OP_WAL_OUT;
      obsc_pkg::OP_INS_INIT: begin
        if (st.side_full) state_next = obsc_pkg::OP_FULL;
        else if (st.side_empty) state_next = obsc_pkg::OP_INS_PUT;
        else state_next = obsc_pkg::OP_INS_RD;
      end
      obsc_pkg::OP_INS_RD:   state_next = obsc_pkg::OP_INS_CMP;
      obsc_pkg::OP_INS_CMP: begin
        if (st.ins_shift && !st.p_is_one) state_next = obsc_pkg::OP_INS_RD;
        else state_next = obsc_pkg::OP_INS_PUT;
      end
      obsc_pkg::OP_M_INIT:   state_next = obsc_pkg::OP_M_TEST;
      obsc_pkg::OP_M_TEST:
        state_next = st.loop_more ? obsc_pkg::OP_M_RD : obsc_pkg::OP_BC_TEST;
      obsc_pkg::OP_M_RD:     state_next = obsc_pkg::OP_M_PAIR;
      obsc_pkg::OP_M_PAIR:   state_next = obsc_pkg::OP_M_COST;
      obsc_pkg::OP_M_COST:   state_next = obsc_pkg::OP_M_CHK;
      obsc_pkg::OP_M_CHK:
        state_next = st.trade_ok ? obsc_pkg::OP_M_PAY : obsc_pkg::OP_M_KEEP;
      obsc_pkg::OP_M_KEEP:   state_next = obsc_pkg::OP_M_TEST;
      obsc_pkg::OP_M_PAY:    state_next = obsc_pkg::OP_M_SRD;
      obsc_pkg::OP_M_SRD:    state_next = obsc_pkg::OP_M_SPUT;
      obsc_pkg::OP_M_SPUT:   state_next = obsc_pkg::OP_RD_CASH_B;
      obsc_pkg::OP_RD_CASH_B: state_next = obsc_pkg::OP_FMAG_B;
      obsc_pkg::OP_FMAG_B:   state_next = obsc_pkg::OP_FHI_B;
      obsc_pkg::OP_FHI_B:    state_next = obsc_pkg::OP_FLO_B;
      obsc_pkg::OP_FLO_B:    state_next = obsc_pkg::OP_FPUT_B;
      obsc_pkg::OP_FPUT_B:   state_next = obsc_pkg::OP_RD_CASH_S;
      obsc_pkg::OP_RD_CASH_S: state_next = obsc_pkg::OP_FMAG_S;
      obsc_pkg::OP_FMAG_S:   state_next = obsc_pkg::OP_FHI_S;
      obsc_pkg::OP_FHI_S:    state_next = obsc_pkg::OP_FLO_S;
      obsc_pkg::OP_FLO_S:    state_next = obsc_pkg::OP_FPUT_S;
      obsc_pkg::OP_FPUT_S:   state_next = obsc_pkg::OP_RD_HOLD_B;
      obsc_pkg::OP_RD_HOLD_B: state_next = obsc_pkg::OP_HPUT_B;
      obsc_pkg::OP_HPUT_B:   state_next = obsc_pkg::OP_RD_HOLD_S;
      obsc_pkg::OP_RD_HOLD_S: state_next = obsc_pkg::OP_HPUT_S;
      obsc_pkg::OP_HPUT_S:   state_next = obsc_pkg::OP_M_ADV;
      obsc_pkg::OP_M_ADV:    state_next = obsc_pkg::OP_M_TEST;
      obsc_pkg::OP_BC_TEST:
        state_next = st.bid_more ? obsc_pkg::OP_BC_RD : obsc_pkg::OP_AC_TEST;
      obsc_pkg::OP_BC_RD:    state_next = obsc_pkg::OP_BC_WR;
      obsc_pkg::OP_BC_WR:    state_next = obsc_pkg::OP_BC_TEST;
      obsc_pkg::OP_AC_TEST:
        state_next = st.ask_more ? obsc_pkg::OP_AC_RD : obsc_pkg::OP_M_END;
      obsc_pkg::OP_AC_RD:    state_next = obsc_pkg::OP_AC_WR;
      obsc_pkg::OP_AC_WR:    state_next = obsc_pkg::OP_AC_TEST;
      default:               state_next = obsc_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= obsc_pkg::OP_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/obsc_dp.sv */
module obsc_dp #(
  parameter int BOOK_DEPTH = 256,
  parameter int NUM_AGENTS = 64,
  parameter int NUM_STOCKS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  obsc_pkg::ctrl_cmd_t                  cmd,
  output obsc_pkg::dp_status_t                 st,
  input  logic [obsc_pkg::CMD_W-1:0]           command,
  input  logic [obsc_pkg::AGENT_IN_W-1:0]      agent_id,
  input  logic [obsc_pkg::STOCK_IN_W-1:0]      stock_id,
  input  logic [obsc_pkg::PRICE_W-1:0]         price,
  input  logic [obsc_pkg::QTY_W-1:0]           quantity,
  input  logic signed [obsc_pkg::CASH_W-1:0]   cash_value,
  input  logic                                 cfg_we,
  input  logic [obsc_pkg::FEE_W-1:0]           cfg_wdata,
  output logic                                 done,
  output logic                                 status,
  output logic [obsc_pkg::PRICE_W-1:0]         clear_price,
  output logic [obsc_pkg::TOTAL_W-1:0]         traded_total,
  output logic [obsc_pkg::TRADES_W-1:0]        trade_count,
  output logic signed [obsc_pkg::CASH_W-1:0]   cash_out,
  output logic signed [obsc_pkg::HOLD_W-1:0]   holding_out
);

  localparam int AGENT_W = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
  localparam int STOCK_W = (NUM_STOCKS > 1) ? $clog2(NUM_STOCKS) : 1;
  localparam int HOLD_DEPTH = NUM_AGENTS * NUM_STOCKS;
  localparam int HIDX_W = $clog2(HOLD_DEPTH);
  localparam int BAW = $clog2(BOOK_DEPTH);
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
  localparam int PW = obsc_pkg::PRICE_W;
  localparam int QW = obsc_pkg::QTY_W;
  localparam int CW = obsc_pkg::CASH_W;
  localparam int HW = obsc_pkg::HOLD_W;
  localparam int E_W = PW + QW + AGENT_W + STOCK_W;
  localparam int S_LO = 0;
  localparam int A_LO = STOCK_W;
  localparam int Q_LO = STOCK_W + AGENT_W;
  localparam int P_LO = Q_LO + QW;
  localparam int AGENT_IN_N = 1 << obsc_pkg::AGENT_IN_W;
  localparam int STOCK_IN_N = 1 << obsc_pkg::STOCK_IN_W;

  // Constant tables folding the input ids onto the configured counts.
  logic [AGENT_W-1:0] agent_mod [AGENT_IN_N];
  logic [STOCK_W-1:0] stock_mod [STOCK_IN_N];
  for (genvar g = 0; g < AGENT_IN_N; g++) begin : g_amod
    assign agent_mod[g] = AGENT_W'(g % NUM_AGENTS);
  end
  for (genvar g = 0; g < STOCK_IN_N; g++) begin : g_smod
    assign stock_mod[g] = STOCK_W'(g % NUM_STOCKS);
  end

  function automatic logic [HIDX_W-1:0] hidx(input logic [AGENT_W-1:0] ag,
                                             input logic [STOCK_W-1:0] sk);
    logic [31:0] full;
    full = 32'(ag) * 32'(NUM_STOCKS) + 32'(sk);
    return full[HIDX_W-1:0];
  endfunction

  // Latched command word
  logic [obsc_pkg::CMD_W-1:0] cmd_l;
  logic [AGENT_W-1:0] agent_l;
  logic [STOCK_W-1:0] stock_l;
  logic [PW-1:0] price_l;
  logic [QW-1:0] qty_l;
  logic [CW-1:0] cash_l;
  logic [obsc_pkg::FEE_W-1:0] fee_keep;

  logic [CNT_W-1:0] bid_count, ask_count, ptr, ib, ia, wb, wa;
  logic [HIDX_W-1:0] clr;
  logic [E_W-1:0] b_e, a_e;
  logic [QW-1:0] q;
  logic [PW-1:0] mid, last;
  logic [obsc_pkg::COST_W-1:0] cost;
  logic signed [HW-1:0] sh;
  logic fneg;
  logic [CW-1:0] mag;
  logic [63:0] hi, lo;
  logic [obsc_pkg::TOTAL_W-1:0] total;
  logic [obsc_pkg::TRADES_W-1:0] trades;

  // RAM ports
  logic bid_we, ask_we, cash_we, hold_we;
  logic [BAW-1:0] bid_wa, bid_ra, ask_wa, ask_ra;
  logic [E_W-1:0] bid_wd, bid_rd, ask_wd, ask_rd;
  logic [AGENT_W-1:0] cash_wa, cash_ra;
  logic [CW-1:0] cash_wd, cash_rd;
  logic [HIDX_W-1:0] hold_wa, hold_ra;
  logic [HW-1:0] hold_wd, hold_rd;

  obsc_ram #(.WIDTH(E_W), .DEPTH(BOOK_DEPTH)) u_bid (
    .clk(clk), .we(bid_we), .waddr(bid_wa), .wdata(bid_wd), .raddr(bid_ra), .rdata(bid_rd)
  );
  obsc_ram #(.WIDTH(E_W), .DEPTH(BOOK_DEPTH)) u_ask (
    .clk(clk), .we(ask_we), .waddr(ask_wa), .wdata(ask_wd), .raddr(ask_ra), .rdata(ask_rd)
  );
  obsc_ram #(.WIDTH(CW), .DEPTH(NUM_AGENTS)) u_cash (
    .clk(clk), .we(cash_we), .waddr(cash_wa), .wdata(cash_wd), .raddr(cash_ra),
    .rdata(cash_rd)
  );
  obsc_ram #(.WIDTH(HW), .DEPTH(HOLD_DEPTH)) u_hold (
    .clk(clk), .we(hold_we), .waddr(hold_wa), .wdata(hold_wd), .raddr(hold_ra),
    .rdata(hold_rd)
  );

  // Entry fields
  logic is_bid;
  logic [CNT_W-1:0] side_cnt;
  logic [E_W-1:0] new_e, ins_rd;
  logic [PW-1:0] b_price, a_price, ins_price;
  logic [QW-1:0] b_qty, a_qty, rb_qty, ra_qty;
  logic [AGENT_W-1:0] b_ag, a_ag;
  logic [HIDX_W-1:0] bidx, sidx, sidx_rd;

  assign is_bid   = (cmd_l == obsc_pkg::CMD_ADD_BID);
  assign side_cnt = is_bid ? bid_count : ask_count;
  assign new_e    = {price_l, qty_l, agent_l, stock_l};
  assign ins_rd   = is_bid ? bid_rd : ask_rd;
  assign ins_price = ins_rd[P_LO +: PW];
  assign b_price  = b_e[P_LO +: PW];
  assign a_price  = a_e[P_LO +: PW];
  assign b_qty    = b_e[Q_LO +: QW];
  assign a_qty    = a_e[Q_LO +: QW];
  assign rb_qty   = bid_rd[Q_LO +: QW];
  assign ra_qty   = ask_rd[Q_LO +: QW];
  assign b_ag     = b_e[A_LO +: AGENT_W];
  assign a_ag     = a_e[A_LO +: AGENT_W];
  assign bidx     = hidx(b_ag, b_e[S_LO +: STOCK_W]);
  assign sidx     = hidx(a_ag, a_e[S_LO +: STOCK_W]);
  assign sidx_rd  = hidx(ask_rd[A_LO +: AGENT_W], ask_rd[S_LO +: STOCK_W]);

  // Arithmetic
  logic [PW:0] mid_sum;
  logic signed [57:0] buyer_ext, cost_ext, seller_sum;
  logic [CW-1:0] seller_sat, fee_res;
  logic [63:0] fee_sum;
  logic [CW-1:0] fee_r;
  logic signed [HW:0] hold_up, hold_dn;
  logic [HW-1:0] hold_up_sat, hold_dn_sat;
  logic [obsc_pkg::TOTAL_W:0] total_sum;
  logic [CW-1:0] cash_abs;

  assign mid_sum    = {1'b0, bid_rd[P_LO +: PW]} + {1'b0, ask_rd[P_LO +: PW]};
  assign buyer_ext  = 58'(signed'(cash_rd));
  assign cost_ext   = signed'({2'b00, cost});
  assign seller_sum = buyer_ext + cost_ext;
  assign seller_sat = (seller_sum > 58'sh7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF
                                                        : seller_sum[CW-1:0];
  assign fee_sum    = hi + {16'd0, lo[63:16]};
  assign fee_r      = fee_sum[CW+15:16];
  assign fee_res    = fneg ? (~fee_r + 1'b1) : fee_r;
  assign cash_abs   = cash_rd[CW-1] ? (~cash_rd + 1'b1) : cash_rd;
  assign hold_up    = signed'({hold_rd[HW-1], hold_rd}) + signed'({9'd0, q});
  assign hold_dn    = signed'({hold_rd[HW-1], hold_rd}) - signed'({9'd0, q});
  assign hold_up_sat = (hold_up[HW] != hold_up[HW-1]) ? {1'b0, {(HW-1){1'b1}}}
                                                      : hold_up[HW-1:0];
  assign hold_dn_sat = (hold_dn[HW] != hold_dn[HW-1]) ? {1'b1, {(HW-1){1'b0}}}
                                                      : hold_dn[HW-1:0];
  assign total_sum  = {1'b0, total} + {9'd0, q};

  // Status
  assign st.cmd        = cmd_l;
  assign st.side_full  = (side_cnt == CNT_W'(BOOK_DEPTH));
  assign st.side_empty = (side_cnt == '0);
  assign st.ins_shift  = is_bid ? (ins_price < price_l) : (ins_price > price_l);
  assign st.p_is_one   = (ptr == CNT_W'(1));
  assign st.loop_more  = (ib < bid_count) && (ia < ask_count);
  assign st.bid_more   = (ib < bid_count);
  assign st.ask_more   = (ia < ask_count);
  assign st.clr_last   = (clr == HIDX_W'(HOLD_DEPTH - 1));
  assign st.trade_ok   = (b_price >= a_price) && (sh > 0) && (buyer_ext >= cost_ext)
                         && (signed'({sh[HW-1], sh}) >= signed'({9'd0, q}));

  // Memory control
  always_comb begin
    bid_we = 1'b0; bid_wa = '0; bid_wd = new_e; bid_ra = ib[BAW-1:0];
    ask_we = 1'b0; ask_wa = '0; ask_wd = new_e; ask_ra = ia[BAW-1:0];
    cash_we = 1'b0; cash_wa = agent_l; cash_wd = cash_l; cash_ra = agent_l;
    hold_we = 1'b0; hold_wa = hidx(agent_l, stock_l); hold_wd = {8'd0, qty_l};
    hold_ra = hidx(agent_l, stock_l);
    case (cmd.op)
      obsc_pkg::OP_CLR: begin
        hold_we = 1'b1; hold_wa = clr; hold_wd = '0;
        cash_we = (32'(clr) < 32'(NUM_AGENTS));
        cash_wa = clr[AGENT_W-1:0]; cash_wd = '0;
      end
      obsc_pkg::OP_LOAD_CASH: cash_we = 1'b1;
      obsc_pkg::OP_LOAD_HOLD: hold_we = 1'b1;
      obsc_pkg::OP_INS_RD: begin
        bid_ra = BAW'(ptr - 1'b1);
        ask_ra = BAW'(ptr - 1'b1);
      end
      obsc_pkg::OP_INS_CMP: begin
        bid_we = is_bid && st.ins_shift; bid_wa = ptr[BAW-1:0]; bid_wd = ins_rd;
        ask_we = !is_bid && st.ins_shift; ask_wa = ptr[BAW-1:0]; ask_wd = ins_rd;
      end
      obsc_pkg::OP_INS_PUT: begin
        bid_we = is_bid; bid_wa = ptr[BAW-1:0];
        ask_we = !is_bid; ask_wa = ptr[BAW-1:0];
      end
      obsc_pkg::OP_M_PAIR:   hold_ra = sidx_rd;
      obsc_pkg::OP_M_COST:   cash_ra = b_ag;
      obsc_pkg::OP_M_KEEP: begin
        bid_we = 1'b1; bid_wa = wb[BAW-1:0]; bid_wd = b_e;
        ask_we = 1'b1; ask_wa = wa[BAW-1:0]; ask_wd = a_e;
      end
      obsc_pkg::OP_M_PAY: begin
        cash_we = 1'b1; cash_wa = b_ag; cash_wd = cash_l - cost[CW-1:0];
      end
      obsc_pkg::OP_M_SRD:    cash_ra = a_ag;
      obsc_pkg::OP_M_SPUT: begin
        cash_we = 1'b1; cash_wa = a_ag; cash_wd = seller_sat;
      end
      obsc_pkg::OP_RD_CASH_B: cash_ra = b_ag;
      obsc_pkg::OP_FPUT_B: begin
        cash_we = 1'b1; cash_wa = b_ag; cash_wd = fee_res;
      end
      obsc_pkg::OP_RD_CASH_S: cash_ra = a_ag;
      obsc_pkg::OP_FPUT_S: begin
        cash_we = 1'b1; cash_wa = a_ag; cash_wd = fee_res;
      end
      obsc_pkg::OP_RD_HOLD_B: hold_ra = bidx;
      obsc_pkg::OP_HPUT_B: begin
        hold_we = 1'b1; hold_wa = bidx; hold_wd = hold_up_sat;
      end
      obsc_pkg::OP_RD_HOLD_S: hold_ra = sidx;
      obsc_pkg::OP_HPUT_S: begin
        hold_we = 1'b1; hold_wa = sidx; hold_wd = hold_dn_sat;
      end
      obsc_pkg::OP_M_ADV: begin
        bid_wa = ib[BAW-1:0];
        bid_wd = {b_price, b_qty - q, b_e[Q_LO-1:0]};
        ask_wa = ia[BAW-1:0];
        ask_wd = {a_price, a_qty - q, a_e[Q_LO-1:0]};
        bid_we = (b_qty > q);
        ask_we = !(b_qty > q) && (a_qty > q);
      end
      obsc_pkg::OP_BC_WR: begin
        bid_we = 1'b1; bid_wa = wb[BAW-1:0]; bid_wd = bid_rd;
      end
      obsc_pkg::OP_AC_WR: begin
        ask_we = 1'b1; ask_wa = wa[BAW-1:0]; ask_wd = ask_rd;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bid_count <= '0;
      ask_count <= '0;
      clr       <= '0;
      fee_keep  <= obsc_pkg::FEE_KEEP_RESET;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) fee_keep <= cfg_wdata;
      case (cmd.op)
        obsc_pkg::OP_CLR: clr <= clr + 1'b1;
        obsc_pkg::OP_EMPTY: begin
          bid_count <= '0;
          ask_count <= '0;
        end
        obsc_pkg::OP_INS_PUT: begin
          if (is_bid) bid_count <= bid_count + 1'b1;
          else ask_count <= ask_count + 1'b1;
        end
        obsc_pkg::OP_M_END: begin
          bid_count <= wb;
          ask_count <= wa;
        end
        default: ;
      endcase
      if (cmd.op == obsc_pkg::OP_LOAD_CASH || cmd.op == obsc_pkg::OP_LOAD_HOLD ||
          cmd.op == obsc_pkg::OP_EMPTY || cmd.op == obsc_pkg::OP_NOP ||
          cmd.op == obsc_pkg::OP_WAL_OUT || cmd.op == obsc_pkg::OP_INS_PUT ||
          cmd.op == obsc_pkg::OP_FULL || cmd.op == obsc_pkg::OP_M_END) begin
        done <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_l   <= command;
      agent_l <= agent_mod[agent_id];
      stock_l <= stock_mod[stock_id];
      price_l <= price;
      qty_l   <= quantity;
      cash_l  <= cash_value;
    end
    case (cmd.op)
      obsc_pkg::OP_INS_INIT: ptr <= side_cnt;
      obsc_pkg::OP_INS_CMP:  if (st.ins_shift) ptr <= ptr - 1'b1;
      obsc_pkg::OP_M_INIT: begin
        ib <= '0; ia <= '0; wb <= '0; wa <= '0;
        total <= '0; trades <= '0; last <= '0;
      end
      obsc_pkg::OP_M_PAIR: begin
        b_e <= bid_rd;
        a_e <= ask_rd;
        q   <= (rb_qty < ra_qty) ? rb_qty : ra_qty;
        mid <= mid_sum[PW:1];
      end
      obsc_pkg::OP_M_COST: begin
        cost <= obsc_pkg::COST_W'(mid * q);
        sh   <= hold_rd;
      end
      obsc_pkg::OP_M_CHK:  cash_l <= cash_rd;
      obsc_pkg::OP_M_KEEP: begin
        ib <= ib + 1'b1; ia <= ia + 1'b1;
        wb <= wb + 1'b1; wa <= wa + 1'b1;
      end
      obsc_pkg::OP_FMAG_B, obsc_pkg::OP_FMAG_S: begin
        fneg <= cash_rd[CW-1];
        mag  <= cash_abs;
      end
      obsc_pkg::OP_FHI_B, obsc_pkg::OP_FHI_S: hi <= 64'(mag * fee_keep[31:16]);
      obsc_pkg::OP_FLO_B, obsc_pkg::OP_FLO_S: lo <= 64'(mag * fee_keep[15:0]);
      obsc_pkg::OP_M_ADV: begin
        total <= total_sum[obsc_pkg::TOTAL_W] ? '1 : total_sum[obsc_pkg::TOTAL_W-1:0];
        if (trades != '1) trades <= trades + 1'b1;
        last <= mid;
        if (b_qty > q) begin
          ia <= ia + 1'b1;
        end else if (a_qty > q) begin
          ib <= ib + 1'b1;
        end else begin
          ib <= ib + 1'b1;
          ia <= ia + 1'b1;
        end
      end
      obsc_pkg::OP_BC_WR: begin
        ib <= ib + 1'b1; wb <= wb + 1'b1;
      end
      obsc_pkg::OP_AC_WR: begin
        ia <= ia + 1'b1; wa <= wa + 1'b1;
      end
      default: ;
    endcase
    if (cmd.op == obsc_pkg::OP_LOAD_CASH || cmd.op == obsc_pkg::OP_LOAD_HOLD ||
        cmd.op == obsc_pkg::OP_EMPTY || cmd.op == obsc_pkg::OP_NOP ||
        cmd.op == obsc_pkg::OP_WAL_OUT || cmd.op == obsc_pkg::OP_INS_PUT ||
        cmd.op == obsc_pkg::OP_FULL || cmd.op == obsc_pkg::OP_M_END) begin
      status       <= (cmd.op == obsc_pkg::OP_FULL);
      clear_price  <= (cmd.op == obsc_pkg::OP_M_END) ? last : '0;
      traded_total <= (cmd.op == obsc_pkg::OP_M_END) ? total : '0;
      trade_count  <= (cmd.op == obsc_pkg::OP_M_END) ? trades : '0;
      cash_out     <= (cmd.op == obsc_pkg::OP_WAL_OUT) ? cash_rd : '0;
      holding_out  <= (cmd.op == obsc_pkg::OP_WAL_OUT) ? hold_rd : '0;
    end
  end

endmodule

/* hdl/order_book_sort_and_clear.sv */
// Limit order book with sorted bid and ask sides and per-agent wallets.
// Pulse start with a command word while busy is low; the word is taken at
// that edge and busy stays high until the result word is presented. Every
// command yields exactly one result word, shown for one cycle with done
// high; the receiver cannot stall it, so capture it on that cycle. The
// book and wallet memories have one read and one write port each and
// register their read data. An add to a side that is neither empty nor
// full compares the new order against the resting orders from the tail,
// shifting each one up that it must pass, until it finds its place. A
// match pairs bid and ask orders from the front of each side, keeps each
// pair that fails its checks, trades each pair that passes, and then
// compacts the remaining orders. After reset the block zeroes the wallets
// with busy high; fee_keep writes are taken at any time but must only be
// made while the block is idle.
module order_book_sort_and_clear #(
  parameter int BOOK_DEPTH = 256,
  parameter int NUM_AGENTS = 64,
  parameter int NUM_STOCKS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [obsc_pkg::CMD_W-1:0]          command,
  input  logic [obsc_pkg::AGENT_IN_W-1:0]     agent_id,
  input  logic [obsc_pkg::STOCK_IN_W-1:0]     stock_id,
  input  logic [obsc_pkg::PRICE_W-1:0]        price,
  input  logic [obsc_pkg::QTY_W-1:0]          quantity,
  input  logic signed [obsc_pkg::CASH_W-1:0]  cash_value,
  input  logic                                cfg_we,
  input  logic [obsc_pkg::FEE_W-1:0]          cfg_wdata,
  output logic                                done,
  output logic                                status,
  output logic [obsc_pkg::PRICE_W-1:0]        clear_price,
  output logic [obsc_pkg::TOTAL_W-1:0]        traded_total,
  output logic [obsc_pkg::TRADES_W-1:0]       trade_count,
  output logic signed [obsc_pkg::CASH_W-1:0]  cash_out,
  output logic signed [obsc_pkg::HOLD_W-1:0]  holding_out
);

  // Step command from the sequencer, flags back from the datapath.
  obsc_pkg::ctrl_cmd_t  cmd;
  obsc_pkg::dp_status_t st;

  obsc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .cmd(cmd), .busy(busy)
  );

  // Books, wallets, match arithmetic and the result register.
  obsc_dp #(
    .BOOK_DEPTH(BOOK_DEPTH), .NUM_AGENTS(NUM_AGENTS), .NUM_STOCKS(NUM_STOCKS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .command(command), .agent_id(agent_id), .stock_id(stock_id), .price(price),
    .quantity(quantity), .cash_value(cash_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .status(status), .clear_price(clear_price),
    .traded_total(traded_total), .trade_count(trade_count),
    .cash_out(cash_out), .holding_out(holding_out)
  );

endmodule

/* verif/order_book_sort_and_clear_test.sv */
`timescale 1ns / 100ps

module order_book_sort_and_clear_test;

  localparam int DEPTH = 256;
  localparam int AGENTS = 64;
  localparam int STOCKS = 4;
  localparam logic signed [obsc_pkg::CASH_W-1:0] CASH_MAX = 48'sh7FFFFFFFFFFF;
  // Command code with no meaning; the block must ignore it.
  localparam logic [obsc_pkg::CMD_W-1:0] CMD_SPARE = 3'd7;

  // One command word as the driver presents it.
  typedef struct {
    logic [obsc_pkg::CMD_W-1:0]         cmd;
    logic [obsc_pkg::AGENT_IN_W-1:0]    agent;
    logic [obsc_pkg::STOCK_IN_W-1:0]    stock;
    logic [obsc_pkg::PRICE_W-1:0]       price;
    logic [obsc_pkg::QTY_W-1:0]         qty;
    logic signed [obsc_pkg::CASH_W-1:0] cash;
    bit                                 is_cfg;   // write fee_keep instead of a command
    bit                                 drain;    // hold off until all results are in
    logic [obsc_pkg::FEE_W-1:0]         fee;
  } word_t;

  // One result word.
  typedef struct {
    logic                               status;
    logic [obsc_pkg::PRICE_W-1:0]       clear_price;
    logic [obsc_pkg::TOTAL_W-1:0]       traded_total;
    logic [obsc_pkg::TRADES_W-1:0]      trade_count;
    logic signed [obsc_pkg::CASH_W-1:0] cash;
    logic signed [obsc_pkg::HOLD_W-1:0] holding;
  } result_t;

  typedef struct {
    logic [obsc_pkg::PRICE_W-1:0] price;
    logic [31:0]                  qty;
    logic [5:0]                   agent;
    logic [1:0]                   stock;
  } order_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [obsc_pkg::CMD_W-1:0] command = '0;
  logic [obsc_pkg::AGENT_IN_W-1:0] agent_id = '0;
  logic [obsc_pkg::STOCK_IN_W-1:0] stock_id = '0;
  logic [obsc_pkg::PRICE_W-1:0] price = '0;
  logic [obsc_pkg::QTY_W-1:0] quantity = '0;
  logic signed [obsc_pkg::CASH_W-1:0] cash_value = '0;
  logic cfg_we = 1'b0;
  logic [obsc_pkg::FEE_W-1:0] cfg_wdata = '0;
  logic done, status;
  logic [obsc_pkg::PRICE_W-1:0] clear_price;
  logic [obsc_pkg::TOTAL_W-1:0] traded_total;
  logic [obsc_pkg::TRADES_W-1:0] trade_count;
  logic signed [obsc_pkg::CASH_W-1:0] cash_out;
  logic signed [obsc_pkg::HOLD_W-1:0] holding_out;

  order_book_sort_and_clear u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .agent_id(agent_id), .stock_id(stock_id),
    .price(price), .quantity(quantity), .cash_value(cash_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .status(status), .clear_price(clear_price),
    .traded_total(traded_total), .trade_count(trade_count),
    .cash_out(cash_out), .holding_out(holding_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the book and wallets.
  order_t bids[$];
  order_t asks[$];
  logic signed [obsc_pkg::CASH_W-1:0] wallet_cash[AGENTS];
  logic signed [obsc_pkg::HOLD_W-1:0] wallet_hold[AGENTS*STOCKS];
  logic [obsc_pkg::FEE_W-1:0] fee_keep_q;

  word_t   pending_words[$];
  result_t awaited_results[$];
  int errors = 0;

  // Scale cash by fee_keep, truncating the magnitude toward zero.
  function automatic logic signed [obsc_pkg::CASH_W-1:0] apply_fee(
      logic signed [obsc_pkg::CASH_W-1:0] c);
    logic [63:0] mag, hi, lo, r;
    mag = (c < 0) ? 64'(-65'(c)) : 64'(c);
    hi = mag * 64'(fee_keep_q[31:16]);
    lo = mag * 64'(fee_keep_q[15:0]);
    r = (hi + (lo >> 16)) >> 16;
    return (c < 0) ? obsc_pkg::CASH_W'(-r) : obsc_pkg::CASH_W'(r);
  endfunction

  function automatic logic signed [obsc_pkg::HOLD_W-1:0] hold_sat(
      logic signed [obsc_pkg::HOLD_W-1:0] h, longint d);
    longint s;
    s = longint'(h) + d;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return obsc_pkg::HOLD_W'(s);
  endfunction

  // Walk both sides pairwise; keep unfilled orders, drop filled ones.
  function automatic void clear_books(ref result_t r);
    order_t kb[$], ka[$];
    order_t b, a;
    int ib, ia, sidx, bidx;
    logic [31:0] q, mid;
    longint cost, sc;
    logic [32:0] total;
    bit ok;
    ib = 0; ia = 0; total = 0;
    while (ib < bids.size() && ia < asks.size()) begin
      b = bids[ib]; a = asks[ia];
      q = (b.qty < a.qty) ? b.qty : a.qty;
      mid = 32'((33'(b.price) + 33'(a.price)) >> 1);
      cost = longint'({32'd0, mid} * {32'd0, q});
      sidx = a.agent * STOCKS + a.stock;
      bidx = b.agent * STOCKS + b.stock;
      ok = b.price >= a.price && wallet_hold[sidx] > 0 &&
           longint'(wallet_cash[b.agent]) >= cost &&
           longint'(wallet_hold[sidx]) >= longint'(q);
      if (!ok) begin
        kb.insert(kb.size(), b); ka.insert(ka.size(), a);
        ib++; ia++;
        continue;
      end
      wallet_cash[b.agent] = obsc_pkg::CASH_W'(longint'(wallet_cash[b.agent]) - cost);
      sc = longint'(wallet_cash[a.agent]) + cost;
      wallet_cash[a.agent] = (sc > longint'(CASH_MAX)) ? CASH_MAX : obsc_pkg::CASH_W'(sc);
      wallet_cash[b.agent] = apply_fee(wallet_cash[b.agent]);
      wallet_cash[a.agent] = apply_fee(wallet_cash[a.agent]);
      wallet_hold[bidx] = hold_sat(wallet_hold[bidx], longint'(q));
      wallet_hold[sidx] = hold_sat(wallet_hold[sidx], -longint'(q));
      total = total + q;
      if (total > 33'hFFFFFFFF) total = 33'hFFFFFFFF;
      if (r.trade_count < 511) r.trade_count++;
      r.clear_price = mid;
      if (b.qty > q) begin
        bids[ib].qty = b.qty - q; ia++;
      end else if (a.qty > q) begin
        asks[ia].qty = a.qty - q; ib++;
      end else begin
        ib++; ia++;
      end
    end
    while (ib < bids.size()) kb.insert(kb.size(), bids[ib++]);
    while (ia < asks.size()) ka.insert(ka.size(), asks[ia++]);
    bids = kb; asks = ka;
    r.traded_total = total[31:0];
  endfunction

  // Predict the result word of one command and update the shadow.
  function automatic result_t predict_book(word_t w);
    result_t r;
    order_t e;
    int p;
    r = '{default: '0};
    e.price = w.price; e.qty = 32'(w.qty); e.agent = w.agent; e.stock = w.stock;
    case (w.cmd)
      obsc_pkg::CMD_LOAD_CASH: wallet_cash[w.agent] = w.cash;
      obsc_pkg::CMD_LOAD_HOLD:
        wallet_hold[w.agent*STOCKS + w.stock] = obsc_pkg::HOLD_W'(w.qty);
      obsc_pkg::CMD_ADD_BID: begin
        if (bids.size() >= DEPTH) r.status = 1'b1;
        else begin
          p = 0;
          while (p < bids.size() && bids[p].price >= e.price) p++;
          bids.insert(p, e);
        end
      end
      obsc_pkg::CMD_ADD_ASK: begin
        if (asks.size() >= DEPTH) r.status = 1'b1;
        else begin
          p = 0;
          while (p < asks.size() && asks[p].price <= e.price) p++;
          asks.insert(p, e);
        end
      end
      obsc_pkg::CMD_MATCH: clear_books(r);
      obsc_pkg::CMD_EMPTY: begin
        bids.delete(); asks.delete();
      end
      obsc_pkg::CMD_READ: begin
        r.cash = wallet_cash[w.agent];
        r.holding = wallet_hold[w.agent*STOCKS + w.stock];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: present one word at a time at the falling edge.
  int gap = 0;
  bit issued = 0;
  bit cfg_pulse = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else if (issued && busy === 1'b0 && start) begin
      // previous start was not taken yet; hold
    end else begin
      cfg_pulse = 1'b0;
      if (start && !issued) issued = 1;
      if (start && busy) begin
        start <= 1'b0;
        issued = 0;
      end
      if (!start || busy) begin
        if (gap > 0) gap--;
        else if (pending_words.size() > 0 && busy == 1'b0 && !start) begin
          if (pending_words[0].is_cfg || pending_words[0].drain) begin
            // configure or pause only with nothing in flight
            if (awaited_results.size() == 0) begin
              if (pending_words[0].is_cfg) begin
                cfg_pulse = 1'b1;
                cfg_wdata <= pending_words[0].fee;
                fee_keep_q = pending_words[0].fee;
              end
              void'(pending_words.pop_front());
            end
          end else begin
            command <= pending_words[0].cmd;
            agent_id <= pending_words[0].agent;
            stock_id <= pending_words[0].stock;
            price <= pending_words[0].price;
            quantity <= pending_words[0].qty;
            cash_value <= pending_words[0].cash;
            start <= 1'b1;
            issued = 0;
            awaited_results.insert(awaited_results.size(),
                                   predict_book(pending_words.pop_front()));
            if ($urandom_range(0, 3) == 0)
              gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(1, 4);
          end
        end
      end
      cfg_we <= cfg_pulse;
    end
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result word with nothing expected", $realtime);
        errors++;
      end else begin
        result_t x;
        x = awaited_results.pop_front();
        if (status !== x.status || clear_price !== x.clear_price ||
            traded_total !== x.traded_total || trade_count !== x.trade_count ||
            cash_out !== x.cash || holding_out !== x.holding) begin
          $display("%0t: mismatch exp st=%0d px=%h tot=%h cnt=%0d cash=%h hold=%h",
                   $realtime, x.status, x.clear_price, x.traded_total, x.trade_count,
                   x.cash, x.holding);
          $display("%0t:          act st=%0d px=%h tot=%h cnt=%0d cash=%h hold=%h",
                   $realtime, status, clear_price, traded_total, trade_count,
                   cash_out, holding_out);
          errors++;
        end
      end
    end
  end

  function automatic word_t mk(logic [obsc_pkg::CMD_W-1:0] c, int ag, int st,
                               logic [obsc_pkg::PRICE_W-1:0] p,
                               logic [obsc_pkg::QTY_W-1:0] q,
                               logic signed [obsc_pkg::CASH_W-1:0] cv);
    word_t w;
    w = '{default: '0};
    w.cmd = c; w.agent = obsc_pkg::AGENT_IN_W'(ag); w.stock = obsc_pkg::STOCK_IN_W'(st);
    w.price = p; w.qty = q; w.cash = cv;
    return w;
  endfunction

  function automatic void add_word(word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic void add_fee(logic [obsc_pkg::FEE_W-1:0] f);
    word_t w;
    w = '{default: '0};
    w.is_cfg = 1; w.fee = f;
    add_word(w);
  endfunction

  function automatic logic [obsc_pkg::PRICE_W-1:0] rand_price();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'h00640000 + $urandom_range(0, 32'h40000);
      default: return 32'h00010000 * $urandom_range(90, 110);
    endcase
  endfunction

  function automatic logic [obsc_pkg::QTY_W-1:0] rand_qty(int hi);
    if ($urandom_range(0, 9) == 0) return obsc_pkg::QTY_W'($urandom());
    return obsc_pkg::QTY_W'($urandom_range(0, hi));
  endfunction

  // Well-formed round: fund agents, place random orders, match, read back.
  function automatic void add_round();
    int n;
    word_t w;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      w = mk(obsc_pkg::CMD_LOAD_CASH, $urandom_range(0, 63), 0, 0, 0,
             ($urandom_range(0, 9) == 0) ? obsc_pkg::CASH_W'({$urandom(), $urandom()})
                                         : 48'sh0000_0100_0000 * $urandom_range(0, 4096));
      add_word(w);
      w = mk(obsc_pkg::CMD_LOAD_HOLD, $urandom_range(0, 63), $urandom_range(0, 3), 0,
             rand_qty(500), 0);
      add_word(w);
    end
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      w = mk($urandom_range(0, 1) ? obsc_pkg::CMD_ADD_BID : obsc_pkg::CMD_ADD_ASK,
             $urandom_range(0, 63), $urandom_range(0, 3), rand_price(), rand_qty(300), 0);
      add_word(w);
    end
    add_word(mk(obsc_pkg::CMD_MATCH, 0, 0, $urandom(), obsc_pkg::QTY_W'($urandom()), 0));
    for (int i = 0; i < 2; i++)
      add_word(mk(obsc_pkg::CMD_READ, $urandom_range(0, 63), $urandom_range(0, 3),
                  $urandom(), obsc_pkg::QTY_W'($urandom()),
                  obsc_pkg::CASH_W'({$urandom(), $urandom()})));
    if ($urandom_range(0, 3) == 0) add_word(mk(obsc_pkg::CMD_EMPTY, 0, 0, 0, 0, 0));
    if ($urandom_range(0, 7) == 0)
      add_word(mk(CMD_SPARE, $urandom(), $urandom(), $urandom(),
                  obsc_pkg::QTY_W'($urandom()), 0));
  endfunction

  initial begin
    word_t w;
    for (int i = 0; i < AGENTS; i++) wallet_cash[i] = '0;
    for (int i = 0; i < AGENTS*STOCKS; i++) wallet_hold[i] = '0;
    fee_keep_q = obsc_pkg::FEE_KEEP_RESET;

    // Directed: wallet extremes, every command, crossing and failing levels.
    add_word(mk(obsc_pkg::CMD_LOAD_CASH, 1, 0, 0, 0, 48'sh0000_1000_0000));
    add_word(mk(obsc_pkg::CMD_LOAD_CASH, 2, 0, 0, 0, CASH_MAX));
    add_word(mk(obsc_pkg::CMD_LOAD_CASH, 63, 0, 0, 0, 48'sh8000_0000_0000));
    add_word(mk(obsc_pkg::CMD_LOAD_HOLD, 2, 3, 0, 24'hFFFFFF, 0));
    add_word(mk(obsc_pkg::CMD_LOAD_HOLD, 1, 1, 0, 24'd50, 0));
    add_word(mk(obsc_pkg::CMD_ADD_BID, 1, 3, 32'h00650000, 24'd10, 0));
    add_word(mk(obsc_pkg::CMD_ADD_BID, 1, 3, 32'h00650000, 24'd5, 0));
    add_word(mk(obsc_pkg::CMD_ADD_ASK, 2, 3, 32'h00640000, 24'd12, 0));
    add_word(mk(obsc_pkg::CMD_ADD_ASK, 2, 3, 32'h00640000, 24'd3, 0));
    add_word(mk(obsc_pkg::CMD_ADD_ASK, 1, 2, 32'h00600000, 24'd7, 0));
    add_word(mk(obsc_pkg::CMD_MATCH, 0, 0, 0, 0, 0));
    add_word(mk(obsc_pkg::CMD_READ, 1, 3, 0, 0, 0));
    add_word(mk(obsc_pkg::CMD_READ, 2, 3, 0, 0, 0));
    add_word(mk(obsc_pkg::CMD_ADD_BID, 2, 0, 32'hFFFFFFFF, 24'd1, 0));
    add_word(mk(obsc_pkg::CMD_ADD_ASK, 63, 1, 32'h00000000, 24'd0, 0));
    add_word(mk(obsc_pkg::CMD_MATCH, 0, 0, 0, 0, 0));
    add_word(mk(obsc_pkg::CMD_EMPTY, 0, 0, 0, 0, 0));
    add_word(mk(CMD_SPARE, 63, 3, 32'hFFFFFFFF, 24'hFFFFFF, 48'sh7FFFFFFFFFFF));
    add_word(mk(obsc_pkg::CMD_READ, 63, 0, 0, 0, 0));

    // Fill the bid side past its depth to see the drop status.
    for (int i = 0; i < DEPTH + 2; i++)
      add_word(mk(obsc_pkg::CMD_ADD_BID, i, i, obsc_pkg::PRICE_W'(DEPTH + 2 - i), 24'd1, 0));
    add_word(mk(obsc_pkg::CMD_EMPTY, 0, 0, 0, 0, 0));

    // Random rounds under several fee settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: add_fee(32'hFFFFFFFF);
        1: add_fee(32'h00000000);
        2: add_fee(32'h80000000);
        3: add_fee($urandom());
        default: add_fee(obsc_pkg::FEE_KEEP_RESET);
      endcase
      for (int r = 0; r < 12; r++) begin
        if (r == 6) begin
          w = '{default: '0};
          w.drain = 1;
          add_word(w);
        end
        add_round();
      end
    end
    // Noise words across all fields.
    for (int i = 0; i < 80; i++)
      add_word(mk(obsc_pkg::CMD_W'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom(),
                  obsc_pkg::QTY_W'($urandom()), obsc_pkg::CASH_W'({$urandom(), $urandom()})));

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (pending_words.size() == 0 && awaited_results.size() == 0);
    // let any trailing work settle
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Give up after a generous bound.
  initial begin
    #500_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* order_book_sort_and_clear.f */
hdl/obsc_pkg.sv
hdl/obsc_ram.sv
hdl/obsc_ctrl.sv
hdl/obsc_dp.sv
hdl/order_book_sort_and_clear.sv
verif/order_book_sort_and_clear_test.sv
